// ===== hw/rtl/mzr_pkg.sv =====
// Shared widths, command codes, control structs and helpers of the MTF zero-run encoder.
`default_nettype none
package mzr_pkg;

  localparam int unsigned MAX_BLOCK_LEN_DEF = 1048576;
  localparam int unsigned ALPHABET_SIZE_DEF = 256;
  localparam int unsigned HIST_BUCKETS      = 20;
  localparam int unsigned HIST_IDX_W        = 5;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned RIDX_W    = 9;
  localparam int unsigned MSYM_W    = 9;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned FREQ_W    = 21;
  localparam int unsigned HIST_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_REGS  = 4;

  localparam int unsigned BYTE_VALS   = 256;
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned CHUNK_CNT_W = 5;
  localparam int unsigned RANK_W      = 9;

  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SYMBOL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_FREQ = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_HIST = 3'd4;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_ERR,
    SRC_FREQ,
    SRC_HIST
  } out_src_e;

  typedef struct packed {
    logic     capture;
    logic     clear_blk;
    logic     rank_start;
    logic     rank_step;
    logic     cmp_load;
    logic     enc_load;
    logic     rec_front;
    logic     flush_init;
    logic     final_prep;
    logic     digit_prep;
    logic     frd;
    logic     rd_reply;
    logic     fwr;
    logic     run_clear;
    logic     n_step;
    logic     out_load;
    out_src_e out_src;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_use;
    logic             rank_last;
    logic             front_hit;
    logic             run_zero;
    logic             n_lt2;
    logic             code_final;
    logic             out_free;
  } dp_stat_t;

  function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n;
  endfunction

  function automatic logic [HIST_IDX_W-1:0] bucket_of(input logic [SYM_W-1:0] p);
    logic [HIST_IDX_W-1:0] b;
    if (p < 8'd16) begin
      b = {1'b0, p[3:0]};
    end else if (p < 8'd32) begin
      b = 5'd16;
    end else if (p < 8'd64) begin
      b = 5'd17;
    end else if (p < 8'd128) begin
      b = 5'd18;
    end else begin
      b = 5'd19;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mzr_if.sv =====
// Channel interfaces of the MTF zero-run encoder: items, results and configuration writes.
`default_nettype none
interface mzr_item_if;
  logic                         valid;
  logic                         ready;
  logic [mzr_pkg::CMD_W-1:0]    cmd;
  logic [mzr_pkg::SYM_W-1:0]    symbol;
  logic [mzr_pkg::RIDX_W-1:0]   read_index;
  modport source (output valid, cmd, symbol, read_index, input ready);
  modport sink   (input valid, cmd, symbol, read_index, output ready);
endinterface

interface mzr_res_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [mzr_pkg::MSYM_W-1:0]   mtf_symbol;
  logic [mzr_pkg::CNT_W-1:0]    count_value;
  logic                         last;
  logic                         error;
  modport source (output valid, kind, mtf_symbol, count_value, last, error, input ready);
  modport sink   (input valid, kind, mtf_symbol, count_value, last, error, output ready);
endinterface

interface mzr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mzr_pkg::CFG_IDX_W-1:0] index;
  logic [mzr_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mzr_ctrl.sv =====
// Sequencing state machine of the MTF zero-run encoder.
`default_nettype none
module mzr_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output mzr_pkg::dp_cmd_t   cmd_o,
  input  wire mzr_pkg::dp_stat_t stat_i,
  output logic               in_ready_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RANK  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_ENC   = 4'd4;
  localparam logic [3:0] S_FLUSH = 4'd5;
  localparam logic [3:0] S_DIGIT = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FWR   = 4'd8;
  localparam logic [3:0] S_RPL   = 4'd9;

  logic [3:0]         state_q, state_d;
  mzr_pkg::out_src_e  src_q, src_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    cmd_o   = '0;
    cmd_o.out_src = mzr_pkg::SRC_CODE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat_i.cmd)
          mzr_pkg::CMD_START: begin
            cmd_o.clear_blk = 1'b1;
            state_d = S_IDLE;
          end
          mzr_pkg::CMD_SYMBOL: begin
            if (stat_i.in_use) begin
              cmd_o.rank_start = 1'b1;
              state_d = S_RANK;
            end else begin
              src_d   = mzr_pkg::SRC_ERR;
              state_d = S_RPL;
            end
          end
          mzr_pkg::CMD_END: begin
            cmd_o.rank_start = 1'b1;
            state_d = S_RANK;
          end
          mzr_pkg::CMD_RD_FREQ: begin
            cmd_o.rd_reply = 1'b1;
            src_d   = mzr_pkg::SRC_FREQ;
            state_d = S_RPL;
          end
          mzr_pkg::CMD_RD_HIST: begin
            src_d   = mzr_pkg::SRC_HIST;
            state_d = S_RPL;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RANK: begin
        cmd_o.rank_step = 1'b1;
        if (stat_i.rank_last) begin
          state_d = (stat_i.cmd == mzr_pkg::CMD_SYMBOL) ? S_CMP : S_FLUSH;
        end
      end
      S_CMP: begin
        cmd_o.cmp_load = 1'b1;
        if (stat_i.front_hit) begin
          cmd_o.rec_front = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ENC;
        end
      end
      S_ENC: begin
        cmd_o.enc_load = 1'b1;
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat_i.run_zero) begin
          cmd_o.final_prep = 1'b1;
        end else begin
          cmd_o.flush_init = 1'b1;
        end
        state_d = stat_i.run_zero ? S_FRD : S_DIGIT;
      end
      S_DIGIT: begin
        cmd_o.digit_prep = 1'b1;
        state_d = S_FRD;
      end
      S_FRD: begin
        cmd_o.frd = 1'b1;
        state_d = S_FWR;
      end
      S_FWR: begin
        if (stat_i.out_free) begin
          cmd_o.fwr      = 1'b1;
          cmd_o.out_load = 1'b1;
          priority if (stat_i.code_final) begin
            state_d = S_IDLE;
          end else if (stat_i.n_lt2) begin
            cmd_o.run_clear = 1'b1;
            state_d = S_FLUSH;
          end else begin
            cmd_o.n_step = 1'b1;
            state_d = S_DIGIT;
          end
        end
      end
      S_RPL: begin
        cmd_o.out_src = src_q;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q   <= mzr_pkg::SRC_CODE;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mzr_dp.sv =====
// Datapath of the MTF zero-run encoder: list cells, rank counter, run, counters, output register.
`default_nettype none
module mzr_dp #(
  parameter int unsigned MAX_BLOCK_LEN = mzr_pkg::MAX_BLOCK_LEN_DEF,
  parameter int unsigned ALPHABET_SIZE = mzr_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mzr_pkg::dp_cmd_t              cmd_i,
  output mzr_pkg::dp_stat_t                  stat_o,
  input  wire logic [mzr_pkg::CMD_W-1:0]     in_cmd_i,
  input  wire logic [mzr_pkg::SYM_W-1:0]     in_symbol_i,
  input  wire logic [mzr_pkg::RIDX_W-1:0]    in_read_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mzr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mzr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_kind_o,
  output logic [mzr_pkg::MSYM_W-1:0]         out_mtf_symbol_o,
  output logic [mzr_pkg::CNT_W-1:0]          out_count_value_o,
  output logic                               out_last_o,
  output logic                               out_error_o
);

  localparam int unsigned LW = $clog2(ALPHABET_SIZE);
  localparam int unsigned FD = ALPHABET_SIZE + 2;
  localparam int unsigned FW = $clog2(FD);
  localparam int unsigned RW = $clog2(MAX_BLOCK_LEN + 1);
  localparam logic [mzr_pkg::RANK_W-1:0] ALPHA_R = mzr_pkg::RANK_W'(ALPHABET_SIZE);
  localparam logic [mzr_pkg::RIDX_W-1:0] FD_R    = mzr_pkg::RIDX_W'(FD);
  localparam logic [RW-1:0]              MAXL_R  = RW'(MAX_BLOCK_LEN);

  // configuration
  logic [mzr_pkg::CFG_W-1:0] in_use_q [mzr_pkg::CFG_REGS];
  logic [mzr_pkg::BYTE_VALS-1:0] bitmap;

  // captured item
  logic [mzr_pkg::CMD_W-1:0]  cmd_q;
  logic [mzr_pkg::SYM_W-1:0]  byte_q;
  logic [mzr_pkg::RIDX_W-1:0] ri_q;

  // rank counter
  logic [mzr_pkg::CHUNK_CNT_W-1:0] chunk_q;
  logic [mzr_pkg::RANK_W-1:0]      rank_q;
  logic [mzr_pkg::RANK_W-1:0]      lim;
  logic [mzr_pkg::CHUNK_W-1:0]     chunk_bits;
  logic [mzr_pkg::CHUNK_W-1:0]     chunk_mask;

  // list cells
  logic [LW-1:0]            list_q [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] match_q;
  logic [LW-1:0]            j_q, j_enc, d;
  logic                     is_sym;

  // run and emitted code
  logic [RW-1:0]               run_q, n_q;
  logic [mzr_pkg::MSYM_W-1:0]  osym_q;
  logic                        code_last_q;

  // counters
  logic [mzr_pkg::HIST_W-1:0]     hist_q [mzr_pkg::HIST_BUCKETS];
  logic [mzr_pkg::CNT_W-1:0]      total_q;
  logic                           rec_en;
  logic [mzr_pkg::HIST_IDX_W-1:0] bsel;

  // frequency memory
  logic [mzr_pkg::FREQ_W-1:0] fmem [FD];
  logic [FD-1:0]              fv_q;
  logic [mzr_pkg::FREQ_W-1:0] frdata_q, fcur, finc;
  logic                       frvalid_q;
  logic                       fren, ri_ok;
  logic [FW-1:0]              fraddr, fwaddr;

  logic [mzr_pkg::CNT_W-1:0]  reply_val;
  logic                       out_free;

  assign bitmap = {in_use_q[3], in_use_q[2], in_use_q[1], in_use_q[0]};
  assign is_sym = (cmd_q == mzr_pkg::CMD_SYMBOL);
  assign d      = rank_q[LW-1:0];

  assign lim = is_sym ? {1'b0, byte_q} : mzr_pkg::RANK_W'(mzr_pkg::BYTE_VALS);
  assign chunk_bits = bitmap[{chunk_q, 3'b000} +: mzr_pkg::CHUNK_W];
  always_comb begin
    logic [mzr_pkg::SYM_W-1:0] idx;
    chunk_mask = '0;
    for (int k = 0; k < mzr_pkg::CHUNK_W; k++) begin
      idx = {chunk_q, 3'(k)};
      chunk_mask[k] = chunk_bits[k] && ({1'b0, idx} < lim) && ({1'b0, idx} < ALPHA_R);
    end
  end

  always_comb begin
    j_enc = '0;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      if (match_q[k]) begin
        j_enc = j_enc | LW'(k);
      end
    end
  end

  assign rec_en = cmd_i.rec_front || (cmd_i.final_prep && is_sym);
  assign bsel   = cmd_i.rec_front ? '0 : mzr_pkg::bucket_of(mzr_pkg::SYM_W'(j_q));

  assign ri_ok  = (ri_q < FD_R);
  assign fren   = cmd_i.frd || (cmd_i.rd_reply && ri_ok);
  assign fraddr = cmd_i.rd_reply ? FW'(ri_q) : FW'(osym_q);
  assign fwaddr = FW'(osym_q);
  assign fcur   = frvalid_q ? frdata_q : '0;
  assign finc   = (fcur == mzr_pkg::FREQ_MAX) ? fcur : fcur + 1'b1;

  always_comb begin
    reply_val = '0;
    if (ri_q < mzr_pkg::RIDX_W'(mzr_pkg::HIST_BUCKETS)) begin
      reply_val = mzr_pkg::CNT_W'(hist_q[ri_q[mzr_pkg::HIST_IDX_W-1:0]]);
    end else if (ri_q == mzr_pkg::RIDX_W'(mzr_pkg::HIST_BUCKETS)) begin
      reply_val = total_q;
    end
  end

  assign out_free = !out_valid_o || out_ready_i;

  assign stat_o.cmd        = cmd_q;
  assign stat_o.in_use     = bitmap[byte_q] && ({1'b0, byte_q} < ALPHA_R);
  assign stat_o.rank_last  = (chunk_q == '1);
  assign stat_o.front_hit  = (list_q[0] == d);
  assign stat_o.run_zero   = (run_q == '0);
  assign stat_o.n_lt2      = (n_q < RW'(2));
  assign stat_o.code_final = code_last_q;
  assign stat_o.out_free   = out_free;

  // payload capture, working registers, frequency memory and output payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_symbol_i;
      ri_q   <= in_read_index_i;
    end
    if (cmd_i.cmp_load) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        match_q[k] <= (list_q[k] == d);
      end
    end
    if (cmd_i.enc_load) begin
      j_q <= j_enc;
    end
    if (cmd_i.flush_init) begin
      n_q <= run_q - 1'b1;
    end else if (cmd_i.n_step) begin
      n_q <= (n_q - RW'(2)) >> 1;
    end
    if (cmd_i.final_prep) begin
      osym_q      <= is_sym ? mzr_pkg::MSYM_W'(j_q) + 1'b1 : rank_q + 1'b1;
      code_last_q <= 1'b1;
    end else if (cmd_i.digit_prep) begin
      osym_q      <= {{(mzr_pkg::MSYM_W-1){1'b0}}, n_q[0]};
      code_last_q <= 1'b0;
    end
    if (cmd_i.fwr) begin
      fmem[fwaddr] <= finc;
    end
    if (fren) begin
      frdata_q <= fmem[fraddr];
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_src)
        mzr_pkg::SRC_CODE: begin
          out_kind_o <= 1'b0; out_mtf_symbol_o <= osym_q; out_count_value_o <= '0;
          out_last_o <= code_last_q; out_error_o <= 1'b0;
        end
        mzr_pkg::SRC_ERR: begin
          out_kind_o <= 1'b0; out_mtf_symbol_o <= '0; out_count_value_o <= '0;
          out_last_o <= 1'b1; out_error_o <= 1'b1;
        end
        mzr_pkg::SRC_FREQ: begin
          out_kind_o <= 1'b1; out_mtf_symbol_o <= '0;
          out_count_value_o <= ri_ok ? mzr_pkg::CNT_W'(fcur) : '0;
          out_last_o <= 1'b1; out_error_o <= 1'b0;
        end
        mzr_pkg::SRC_HIST: begin
          out_kind_o <= 1'b1; out_mtf_symbol_o <= '0; out_count_value_o <= reply_val;
          out_last_o <= 1'b1; out_error_o <= 1'b0;
        end
        default: begin
          out_kind_o <= 1'b0; out_mtf_symbol_o <= '0; out_count_value_o <= '0;
          out_last_o <= 1'b0; out_error_o <= 1'b0;
        end
      endcase
    end
  end

  // state with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mzr_pkg::CFG_REGS; r++) begin
        in_use_q[r] <= '0;
      end
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        list_q[k] <= LW'(k);
      end
      for (int b = 0; b < mzr_pkg::HIST_BUCKETS; b++) begin
        hist_q[b] <= '0;
      end
      chunk_q     <= '0;
      rank_q      <= '0;
      run_q       <= '0;
      total_q     <= '0;
      fv_q        <= '0;
      frvalid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        in_use_q[cfg_index_i] <= cfg_data_i;
      end
      if (cmd_i.rank_start) begin
        chunk_q <= '0;
        rank_q  <= '0;
      end else if (cmd_i.rank_step) begin
        chunk_q <= chunk_q + 1'b1;
        rank_q  <= rank_q + mzr_pkg::RANK_W'(mzr_pkg::popcount8(chunk_mask));
      end
      if (cmd_i.clear_blk) begin
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
          list_q[k] <= LW'(k);
        end
      end else if (cmd_i.final_prep && is_sym) begin
        list_q[0] <= d;
        for (int k = 1; k < ALPHABET_SIZE; k++) begin
          if (LW'(k) <= j_q) begin
            list_q[k] <= list_q[k-1];
          end
        end
      end
      if (cmd_i.clear_blk || cmd_i.run_clear) begin
        run_q <= '0;
      end else if (cmd_i.rec_front && (run_q < MAXL_R)) begin
        run_q <= run_q + 1'b1;
      end
      if (rec_en) begin
        for (int b = 0; b < mzr_pkg::HIST_BUCKETS; b++) begin
          if (bsel == mzr_pkg::HIST_IDX_W'(b)) begin
            hist_q[b] <= hist_q[b] + 1'b1;
          end
        end
        total_q <= total_q + 1'b1;
      end
      if (cmd_i.clear_blk) begin
        fv_q <= '0;
      end else if (cmd_i.fwr) begin
        fv_q[fwaddr] <= 1'b1;
      end
      if (fren) begin
        frvalid_q <= fv_q[fraddr];
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mtf_zero_run_encoder.sv =====
// Top level of the move-to-front encoder with RUNA/RUNB zero-run output.
`default_nettype none
// The block takes one command beat at a time and works on it alone; the input
// is ready only while the sequencer is idle. A symbol beat first ranks the byte
// against the in-use bitmap, eight bitmap bits per cycle; then the list cells
// are compared in parallel, the hit position is encoded, and the list shifts
// all at once. A byte equal to the front of the list ends after the compare
// with no result. Every emitted code (each RUNA/RUNB digit and the final
// position or EOB) goes through a frequency read-modify-write in the counter
// memory and waits while the output register is held by a stalled sink. End
// block runs the same steps as a symbol minus the list search. The output
// register lets the last beat wait while the next command is taken. Frequency
// counters are cleared by start block and reset at once through per-entry
// valid flags; there is no clearing pass. Configuration writes are always
// ready and must only be issued while the block is idle.
module mtf_zero_run_encoder #(
  parameter int unsigned MAX_BLOCK_LEN = mzr_pkg::MAX_BLOCK_LEN_DEF,
  parameter int unsigned ALPHABET_SIZE = mzr_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mzr_item_if.sink   in_i,
  mzr_res_if.source  out_o,
  mzr_cfg_if.sink    cfg_i
);

  mzr_pkg::dp_cmd_t  dp_cmd;
  mzr_pkg::dp_stat_t dp_stat;
  logic              in_ready;

  // configuration channel never stalls
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  mzr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready)
  );

  mzr_dp #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .in_cmd_i          (in_i.cmd),
    .in_symbol_i       (in_i.symbol),
    .in_read_index_i   (in_i.read_index),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_kind_o        (out_o.kind),
    .out_mtf_symbol_o  (out_o.mtf_symbol),
    .out_count_value_o (out_o.count_value),
    .out_last_o        (out_o.last),
    .out_error_o       (out_o.error)
  );

  // never overwrite a result beat that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> dp_stat.out_free) else $error("result register overwritten");

  // every counter bump goes with a coded beat
  a_fwr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.fwr |-> (dp_cmd.out_load && dp_cmd.out_src == mzr_pkg::SRC_CODE))
    else $error("frequency bump without coded beat");

  // one command beat at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("second beat taken early");

  // start block leaves no pending run
  a_clear_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clear_blk |=> dp_stat.run_zero) else $error("run survived start block");

  // the final code is only built once the run is flushed
  a_final_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.final_prep |-> dp_stat.run_zero) else $error("final code before run flush");

endmodule
`default_nettype wire
